### src/seum_pkg.sv
`timescale 1ns / 1ps

package seum_pkg;

  // configuration port geometry
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  // fixed register widths
  localparam int PAT_CHARS_W = 64;
  localparam int PAT_LEN_W   = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_CHARS  = 3'd0,
    REG_PATTERN_LENGTH = 3'd1,
    REG_ANY_MODE       = 3'd2,
    REG_SOURCE_LENGTH  = 3'd3,
    REG_START_INDEX    = 3'd4
  } cfg_reg_t;

  // per-cell compare flags
  typedef struct packed {
    logic seq_ok;   // aligned pattern char matches, or cell outside pattern
    logic any_hit;  // new char equals this cell's pattern char
  } cell_flags_t;

endpackage

### src/string_extract_until_match.sv
`timescale 1ns / 1ps

// Prefix extract by pattern search over a character stream.
// Configure pattern, pattern length, mode, source length and start index
// through the write port while no string is in flight. Then send the
// source_length characters of the string on the input channel, one per beat.
// Each beat enters a row of PATTERN_MAX window cells that compare in
// parallel, so one character is taken every cycle unless the input is stalled.
// On the last character one result beat (extract_length, match_found,
// null_result) is loaded into the output register and shows up in the cycle
// after that character was accepted. Per-string state then clears and the
// next character begins a new string. With source_length zero, characters
// are taken and dropped without a result.
// The output register frees in the same cycle its beat is taken; the input
// is stalled only while a result waits and the receiver stalls.
// Reset (synchronous) clears the string state and the output valid, sets
// all configuration registers to zero except start_index, which becomes one.
module string_extract_until_match #(
  parameter int PATTERN_MAX = 8,
  parameter int CHAR_BITS   = 8,
  parameter int LEN_BITS    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [seum_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [seum_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [CHAR_BITS-1:0]             src_char,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [LEN_BITS-1:0]              extract_length,
  output logic                             match_found,
  output logic                             null_result
);
  import seum_pkg::*;

  localparam int PL_W  = $clog2(PATTERN_MAX + 1);
  localparam int SW    = LEN_BITS + 2;
  localparam int PV_W  = PATTERN_MAX * CHAR_BITS + PAT_CHARS_W;

  // configuration registers
  logic [PAT_CHARS_W-1:0] pattern_chars;
  logic [PAT_LEN_W-1:0]   pattern_length;
  logic                   any_mode;
  logic [LEN_BITS-1:0]    source_length;
  logic [LEN_BITS:0]      start_index;

  // string state
  logic [LEN_BITS-1:0]    position_count;
  logic                   found_flag;
  logic [LEN_BITS-1:0]    found_length;

  logic                   in_accept;
  logic                   active;
  logic [PV_W-1:0]        pat_vec;
  logic [PATTERN_MAX-1:0][CHAR_BITS-1:0] pattern;
  logic [PATTERN_MAX-1:0][CHAR_BITS-1:0] window;
  cell_flags_t [PATTERN_MAX-1:0]         flags;
  logic [4:0]             plen_wide;
  logic [PL_W-1:0]        plen;

  logic signed [SW-1:0]   start_ext;
  logic signed [SW-1:0]   start_adj;
  logic signed [SW-1:0]   start_clamp;
  logic [LEN_BITS-1:0]    start_eff;
  logic [LEN_BITS:0]      q;
  logic [LEN_BITS+1:0]    q_plus;
  logic [LEN_BITS+1:0]    s_plus_plen;
  logic                   any_hit;
  logic                   seq_hit;
  logic                   found_next;
  logic [LEN_BITS-1:0]    found_length_next;
  logic                   last_char;
  logic [LEN_BITS-1:0]    remainder;
  logic                   null_case;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars  <= '0;
      pattern_length <= '0;
      any_mode       <= 1'b0;
      source_length  <= '0;
      start_index    <= (LEN_BITS + 1)'(1);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_CHARS:  pattern_chars  <= cfg_data[PAT_CHARS_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[PAT_LEN_W-1:0];
        REG_ANY_MODE:       any_mode       <= cfg_data[0];
        REG_SOURCE_LENGTH:  source_length  <= cfg_data[LEN_BITS-1:0];
        REG_START_INDEX:    start_index    <= cfg_data[LEN_BITS:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign active    = in_accept && (source_length != '0);

  // pattern chars unpacked, chars past the register read as zero
  assign pat_vec = {{(PATTERN_MAX * CHAR_BITS){1'b0}}, pattern_chars};

  // pattern length clamped to the window size
  assign plen_wide = (5'(pattern_length) > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX)
                                                            : 5'(pattern_length);
  assign plen      = PL_W'(plen_wide);

  // window row, newest char in cell zero
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [CHAR_BITS-1:0] cin;

    assign pattern[k] = pat_vec[k*CHAR_BITS +: CHAR_BITS];

    if (k == 0) begin : g_head
      assign cin = src_char;
    end else begin : g_link
      assign cin = window[k-1];
    end

    seum_cell #(
      .PATTERN_MAX (PATTERN_MAX),
      .CHAR_BITS   (CHAR_BITS),
      .IDX         (k)
    ) u_cell (
      .clk      (clk),
      .shift    (active),
      .char_in  (cin),
      .new_char (src_char),
      .pattern  (pattern),
      .plen     (plen),
      .char_out (window[k]),
      .flags    (flags[k])
    );
  end

  // effective one-based start
  assign start_ext   = {start_index[LEN_BITS], start_index};
  assign start_adj   = start_index[LEN_BITS] ?
                       (SW'(source_length) + start_ext + SW'(1)) : start_ext;
  assign start_clamp = (start_adj < SW'(1)) ? SW'(1) : start_adj;
  assign start_eff   = start_clamp[LEN_BITS-1:0];

  // position of the current char and match detection
  assign q           = (LEN_BITS + 1)'(position_count) + (LEN_BITS + 1)'(1);
  assign q_plus      = (LEN_BITS + 2)'(q) + (LEN_BITS + 2)'(1);
  assign s_plus_plen = (LEN_BITS + 2)'(start_eff) + (LEN_BITS + 2)'(plen);

  always_comb begin
    any_hit = 1'b0;
    seq_hit = 1'b1;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      any_hit = any_hit | flags[k].any_hit;
      seq_hit = seq_hit & flags[k].seq_ok;
    end
  end

  always_comb begin
    found_next        = found_flag;
    found_length_next = found_length;
    if (!found_flag && (plen != '0)) begin
      if (any_mode) begin
        if ((q >= (LEN_BITS + 1)'(start_eff)) && any_hit) begin
          found_next        = 1'b1;
          found_length_next = LEN_BITS'(q - (LEN_BITS + 1)'(start_eff));
        end
      end else begin
        if ((q_plus >= s_plus_plen) && seq_hit) begin
          found_next        = 1'b1;
          found_length_next = LEN_BITS'(q_plus - s_plus_plen);
        end
      end
    end
  end

  // end of string and result fields
  assign last_char = q >= (LEN_BITS + 1)'(source_length);
  assign remainder = (start_eff > source_length) ? '0
                     : (source_length - start_eff + LEN_BITS'(1));
  assign null_case = (pattern_length != '0) && (start_index == '0);

  // string state update
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      found_flag     <= 1'b0;
      found_length   <= '0;
    end else if (active) begin
      if (last_char) begin
        position_count <= '0;
        found_flag     <= 1'b0;
        found_length   <= '0;
      end else begin
        position_count <= q[LEN_BITS-1:0];
        found_flag     <= found_next;
        found_length   <= found_length_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (active && last_char) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (active && last_char) begin
      if (null_case) begin
        extract_length <= '0;
        match_found    <= 1'b0;
        null_result    <= 1'b1;
      end else if ((plen == '0) || !found_next) begin
        extract_length <= remainder;
        match_found    <= 1'b0;
        null_result    <= 1'b0;
      end else begin
        extract_length <= found_length_next;
        match_found    <= 1'b1;
        null_result    <= 1'b0;
      end
    end
  end

endmodule

### src/seum_cell.sv
`timescale 1ns / 1ps

module seum_cell #(
  parameter int PATTERN_MAX = 8,
  parameter int CHAR_BITS   = 8,
  parameter int IDX         = 0
) (
  input  logic                                     clk,
  input  logic                                     shift,
  input  logic [CHAR_BITS-1:0]                     char_in,
  input  logic [CHAR_BITS-1:0]                     new_char,
  input  logic [PATTERN_MAX-1:0][CHAR_BITS-1:0]    pattern,
  input  logic [$clog2(PATTERN_MAX+1)-1:0]         plen,
  output logic [CHAR_BITS-1:0]                     char_out,
  output seum_pkg::cell_flags_t                    flags
);
  import seum_pkg::*;

  localparam int PL_W = $clog2(PATTERN_MAX + 1);
  localparam int IW   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [CHAR_BITS-1:0] char_q;
  logic                 in_pattern;
  logic [PL_W-1:0]      align_wide;
  logic [IW-1:0]        align_idx;

  // window stage, hands its char to the next cell on each beat
  always_ff @(posedge clk) begin
    if (shift) begin
      char_q <= char_in;
    end
  end

  assign char_out = char_q;

  // this cell lines up with pattern char plen-1-IDX
  assign in_pattern = PL_W'(IDX) < plen;
  assign align_wide = plen - PL_W'(1) - PL_W'(IDX);
  assign align_idx  = IW'(align_wide);

  // seq_ok compares against the char that enters this cell on the current beat, any_hit against the new char
  always_comb begin
    flags.seq_ok  = !in_pattern || (char_in == pattern[align_idx]);
    flags.any_hit = in_pattern && (new_char == pattern[IDX]);
  end

endmodule
